@@ design/tcaabb_pkg.sv @@
// Shared types and constants for the transformed corner bounding box unit.
// No dependencies; every other design file refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package tcaabb_pkg;

   localparam int COORD_W  = 16;
   localparam int WORLD_W  = 24;
   localparam int ROW_W    = 64;
   localparam int PROD_W   = 2 * COORD_W;
   localparam int FRAC_SH  = 12;
   localparam int CSR_IDX_W = 2;

   // Corner queue between the transform front end and the min/max back end
   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ROW_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_Z = 2'd2;

   // Identity matrix at reset
   localparam logic [ROW_W-1:0] ROW_X_RESET = 64'h0000_0000_0000_1000;
   localparam logic [ROW_W-1:0] ROW_Y_RESET = 64'h0000_0000_1000_0000;
   localparam logic [ROW_W-1:0] ROW_Z_RESET = 64'h0000_1000_0000_0000;

   // One world-space corner travelling through the queue
   typedef struct packed {
      logic                       last;
      logic signed [WORLD_W-1:0]  wx;
      logic signed [WORLD_W-1:0]  wy;
      logic signed [WORLD_W-1:0]  wz;
   } corner_item_type;

   // One finished bounding box
   typedef struct packed {
      logic signed [WORLD_W-1:0]  min_x;
      logic signed [WORLD_W-1:0]  min_y;
      logic signed [WORLD_W-1:0]  min_z;
      logic signed [WORLD_W-1:0]  max_x;
      logic signed [WORLD_W-1:0]  max_y;
      logic signed [WORLD_W-1:0]  max_z;
   } box_type;

   // Queue status seen by the front end for its credit check
   typedef struct packed {
      logic              empty;
      logic [QCNT_W-1:0] level;
   } queue_status_type;

endpackage

`default_nettype wire

@@ design/tcaabb_front.sv @@
// Front end: accepts corners, holds the matrix registers and transforms corners to world space.
// Depends on tcaabb_pkg; feeds tcaabb_queue.
`timescale 1ns / 1ps
`default_nettype none

module tcaabb_front (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_push,
   output logic                                        req_full,
   input  wire logic signed [tcaabb_pkg::COORD_W-1:0]  req_corner_x,
   input  wire logic signed [tcaabb_pkg::COORD_W-1:0]  req_corner_y,
   input  wire logic signed [tcaabb_pkg::COORD_W-1:0]  req_corner_z,
   input  wire logic                                   req_last_corner,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [tcaabb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [tcaabb_pkg::ROW_W-1:0]           csr_wdata,
   input  wire tcaabb_pkg::queue_status_type           q_status,
   output logic                                        q_push,
   output tcaabb_pkg::corner_item_type                 q_item
);

   logic [2:0][tcaabb_pkg::ROW_W-1:0]           row_ff;
   logic                                        prod_valid_ff;
   logic                                        prod_last_ff;
   logic signed [tcaabb_pkg::PROD_W-1:0]        prod_ff [3][3];
   logic signed [tcaabb_pkg::COORD_W-1:0]       corner [3];
   logic signed [tcaabb_pkg::COORD_W-1:0]       offset [3];
   logic signed [tcaabb_pkg::PROD_W-tcaabb_pkg::FRAC_SH-1:0] scaled [3][3];
   logic signed [tcaabb_pkg::WORLD_W-1:0]       world [3];
   logic [tcaabb_pkg::QCNT_W-1:0]               committed;
   logic                                        accept;

   assign corner[0] = req_corner_x;
   assign corner[1] = req_corner_y;
   assign corner[2] = req_corner_z;

   // Reserve a queue slot for the corner still in the multiply stage.
   assign committed = q_status.level + {{(tcaabb_pkg::QCNT_W-1){1'b0}}, prod_valid_ff};
   assign req_full  = (committed >= tcaabb_pkg::QCNT_W'(tcaabb_pkg::QDEPTH));
   assign accept    = req_push && !req_full;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0] <= tcaabb_pkg::ROW_X_RESET;
         row_ff[1] <= tcaabb_pkg::ROW_Y_RESET;
         row_ff[2] <= tcaabb_pkg::ROW_Z_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            tcaabb_pkg::REG_ROW_X: row_ff[0] <= csr_wdata;
            tcaabb_pkg::REG_ROW_Y: row_ff[1] <= csr_wdata;
            tcaabb_pkg::REG_ROW_Z: row_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= accept;
      end
   end

   // Nine independent 16x16 products, one register stage.
   always_ff @(posedge clock) begin
      if (accept) begin
         prod_last_ff <= req_last_corner;
         for (int a = 0; a < 3; a++) begin
            for (int k = 0; k < 3; k++) begin
               prod_ff[a][k] <=
                  $signed(row_ff[a][tcaabb_pkg::COORD_W*k +: tcaabb_pkg::COORD_W]) * corner[k];
            end
         end
      end
   end

   // Floor shift by 12 is the top 20 bits of each product; add the translation.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         offset[a] = row_ff[a][tcaabb_pkg::ROW_W-1 -: tcaabb_pkg::COORD_W];
         for (int k = 0; k < 3; k++) begin
            scaled[a][k] = prod_ff[a][k][tcaabb_pkg::PROD_W-1:tcaabb_pkg::FRAC_SH];
         end
         world[a] = tcaabb_pkg::WORLD_W'(offset[a])
                  + tcaabb_pkg::WORLD_W'(scaled[a][0])
                  + tcaabb_pkg::WORLD_W'(scaled[a][1])
                  + tcaabb_pkg::WORLD_W'(scaled[a][2]);
      end
   end

   assign q_push      = prod_valid_ff;
   assign q_item.last = prod_last_ff;
   assign q_item.wx   = world[0];
   assign q_item.wy   = world[1];
   assign q_item.wz   = world[2];

endmodule

`default_nettype wire

@@ design/tcaabb_queue.sv @@
// Short corner queue between the front end and the back end.
// Depends on tcaabb_pkg for the item type and depth.
`timescale 1ns / 1ps
`default_nettype none

module tcaabb_queue (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push,
   input  wire tcaabb_pkg::corner_item_type   push_item,
   input  wire logic                          pop,
   output tcaabb_pkg::corner_item_type        head_item,
   output tcaabb_pkg::queue_status_type       status
);

   tcaabb_pkg::corner_item_type           slot_ff [tcaabb_pkg::QDEPTH];
   logic [tcaabb_pkg::QPTR_W-1:0]         wr_ptr_ff;
   logic [tcaabb_pkg::QPTR_W-1:0]         rd_ptr_ff;
   logic [tcaabb_pkg::QCNT_W-1:0]         level_ff;
   logic [tcaabb_pkg::QCNT_W-1:0]         level_in;
   logic                                  do_pop;

   assign do_pop = pop && (level_ff != '0);

   always_comb begin
      level_in = level_ff;
      if (push && !do_pop) begin
         level_in = level_ff + 1'b1;
      end else if (!push && do_pop) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         level_ff <= level_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item    = slot_ff[rd_ptr_ff];
   assign status.empty = (level_ff == '0);
   assign status.level = level_ff;

endmodule

`default_nettype wire

@@ design/tcaabb_back.sv @@
// Back end: running per-axis minimum and maximum, and the result register.
// Depends on tcaabb_pkg; drains tcaabb_queue.
`timescale 1ns / 1ps
`default_nettype none

module tcaabb_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tcaabb_pkg::queue_status_type  q_status,
   input  wire tcaabb_pkg::corner_item_type   q_item,
   output logic                               q_pop,
   input  wire logic                          rsp_pop,
   output logic                               rsp_empty,
   output tcaabb_pkg::box_type                rsp_box
);

   logic                                      first_ff;
   logic                                      res_valid_ff;
   tcaabb_pkg::box_type                       res_ff;
   logic signed [tcaabb_pkg::WORLD_W-1:0]     min_ff [3];
   logic signed [tcaabb_pkg::WORLD_W-1:0]     max_ff [3];
   logic signed [tcaabb_pkg::WORLD_W-1:0]     min_in [3];
   logic signed [tcaabb_pkg::WORLD_W-1:0]     max_in [3];
   logic signed [tcaabb_pkg::WORLD_W-1:0]     w [3];
   logic                                      slot_free;

   assign w[0] = q_item.wx;
   assign w[1] = q_item.wy;
   assign w[2] = q_item.wz;

   // A last corner needs the result register free, or being emptied this cycle.
   assign slot_free = !res_valid_ff || rsp_pop;
   assign q_pop     = !q_status.empty && (!q_item.last || slot_free);

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         if (first_ff) begin
            min_in[a] = w[a];
            max_in[a] = w[a];
         end else begin
            min_in[a] = (w[a] < min_ff[a]) ? w[a] : min_ff[a];
            max_in[a] = (w[a] > max_ff[a]) ? w[a] : max_ff[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff     <= 1'b1;
         res_valid_ff <= 1'b0;
         for (int a = 0; a < 3; a++) begin
            min_ff[a] <= '0;
            max_ff[a] <= '0;
         end
      end else begin
         if (rsp_pop) begin
            res_valid_ff <= 1'b0;
         end
         if (q_pop) begin
            first_ff <= q_item.last;
            for (int a = 0; a < 3; a++) begin
               min_ff[a] <= min_in[a];
               max_ff[a] <= max_in[a];
            end
            if (q_item.last) begin
               res_valid_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && q_item.last) begin
         res_ff.min_x <= min_in[0];
         res_ff.min_y <= min_in[1];
         res_ff.min_z <= min_in[2];
         res_ff.max_x <= max_in[0];
         res_ff.max_y <= max_in[1];
         res_ff.max_z <= max_in[2];
      end
   end

   assign rsp_empty = !res_valid_ff;
   assign rsp_box   = res_ff;

endmodule

`default_nettype wire

@@ design/transformed_corner_aabb_unit.sv @@
// Transformed corner bounding box unit: one corner per cycle sustained while req_full stays low.
// A last corner's box reaches the result ports through the multiply stage, a slot of the
// four-entry corner queue, and the min/max update into the result register.
// The result register frees as it is popped, so a new box may follow every cycle.
// Reset (synchronous) restores the identity matrix, empties the queue and the
// result register, and starts a new run with zeroed running bounds.
`timescale 1ns / 1ps
`default_nettype none

module transformed_corner_aabb_unit (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_push,
   output logic                                        req_full,
   input  wire logic signed [tcaabb_pkg::COORD_W-1:0]  req_corner_x,
   input  wire logic signed [tcaabb_pkg::COORD_W-1:0]  req_corner_y,
   input  wire logic signed [tcaabb_pkg::COORD_W-1:0]  req_corner_z,
   input  wire logic                                   req_last_corner,
   output logic                                        rsp_empty,
   input  wire logic                                   rsp_pop,
   output logic signed [tcaabb_pkg::WORLD_W-1:0]       rsp_min_x,
   output logic signed [tcaabb_pkg::WORLD_W-1:0]       rsp_min_y,
   output logic signed [tcaabb_pkg::WORLD_W-1:0]       rsp_min_z,
   output logic signed [tcaabb_pkg::WORLD_W-1:0]       rsp_max_x,
   output logic signed [tcaabb_pkg::WORLD_W-1:0]       rsp_max_y,
   output logic signed [tcaabb_pkg::WORLD_W-1:0]       rsp_max_z,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [tcaabb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [tcaabb_pkg::ROW_W-1:0]           csr_wdata
);

   tcaabb_pkg::queue_status_type  q_status;
   tcaabb_pkg::corner_item_type   q_push_item;
   tcaabb_pkg::corner_item_type   q_head_item;
   tcaabb_pkg::box_type           box;
   logic                          q_push;
   logic                          q_pop;
   logic                          out_pop;

   assign out_pop = rsp_pop && !rsp_empty;

   tcaabb_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_corner_x    (req_corner_x),
      .req_corner_y    (req_corner_y),
      .req_corner_z    (req_corner_z),
      .req_last_corner (req_last_corner),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .q_status        (q_status),
      .q_push          (q_push),
      .q_item          (q_push_item)
   );

   tcaabb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .pop       (q_pop),
      .head_item (q_head_item),
      .status    (q_status)
   );

   tcaabb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_item    (q_head_item),
      .q_pop     (q_pop),
      .rsp_pop   (out_pop),
      .rsp_empty (rsp_empty),
      .rsp_box   (box)
   );

   assign rsp_min_x = box.min_x;
   assign rsp_min_y = box.min_y;
   assign rsp_min_z = box.min_z;
   assign rsp_max_x = box.max_x;
   assign rsp_max_y = box.max_y;
   assign rsp_max_z = box.max_z;

endmodule

`default_nettype wire
